// File: src/dcrm_pkg.sv
package dcrm_pkg;

    localparam int KeyW     = 4;
    localparam int MouseW   = 16;
    localparam int WheelW   = 17;
    localparam int RampW    = 14;
    localparam int TurnW    = 15;
    localparam int StepW    = 8;
    localparam int DecayW   = 12;
    localparam int BandW    = 8;
    localparam int ClampW   = 8;
    localparam int LimitW   = 14;
    localparam int AddrW    = 5;
    localparam int DataW    = 32;

    // register index, taken from paddr[4:2]
    localparam logic [2:0] RegRampStep  = 3'd0;
    localparam logic [2:0] RegDecayStep = 3'd1;
    localparam logic [2:0] RegDeadband  = 3'd2;
    localparam logic [2:0] RegTurnClamp = 3'd3;
    localparam logic [2:0] RegRampLimit = 3'd4;

    localparam logic [StepW-1:0]  RstRampStep  = 8'd5;
    localparam logic [DecayW-1:0] RstDecayStep = 12'd500;
    localparam logic [BandW-1:0]  RstDeadband  = 8'd10;
    localparam logic [ClampW-1:0] RstTurnClamp = 8'd5;
    localparam logic [LimitW-1:0] RstRampLimit = 14'd16383;

    // ceil(2^17 / 3): exact quotient by three for magnitudes up to 2^15
    localparam logic [15:0] RecipThree = 16'd43691;
    localparam int          RecipShift = 17;

    // which key bit drives which ramp
    localparam int KeyFwd   = 0;
    localparam int KeyBack  = 1;
    localparam int KeyLeft  = 2;
    localparam int KeyRight = 3;

    typedef logic [RampW-1:0]        t_ramp;
    typedef logic signed [TurnW-1:0] t_turn;

endpackage

// File: src/drive_command_ramp_mixer.sv
// channel   valid        stall        payload
// input     i_in_valid   o_in_stall   i_key_bits, i_mouse_x
// output    o_out_valid  i_out_stall  o_wheel_speed_0 .. o_wheel_speed_3
// config    psel/penable pready=1     paddr, pwdata, prdata (apb, 32 bit)
//
// one beat per clock sustained while the output is not stalled; each input beat passes
// through the input register, then ramp update and mix into the result register
// i_rst_n is synchronous, active low: ramps go to zero, registers to defaults
// a stalled result holds; the input register still fills, then o_in_stall rises
module drive_command_ramp_mixer (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [dcrm_pkg::KeyW-1:0]            i_key_bits,
    input  logic signed [dcrm_pkg::MouseW-1:0]   i_mouse_x,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic signed [dcrm_pkg::WheelW-1:0]   o_wheel_speed_0,
    output logic signed [dcrm_pkg::WheelW-1:0]   o_wheel_speed_1,
    output logic signed [dcrm_pkg::WheelW-1:0]   o_wheel_speed_2,
    output logic signed [dcrm_pkg::WheelW-1:0]   o_wheel_speed_3,
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [dcrm_pkg::AddrW-1:0]           paddr,
    input  logic [dcrm_pkg::DataW-1:0]           pwdata,
    output logic [dcrm_pkg::DataW-1:0]           prdata,
    output logic                                 pready
);
    import dcrm_pkg::*;

    logic [StepW-1:0]  r_ramp_step;
    logic [DecayW-1:0] r_decay_step;
    logic [BandW-1:0]  r_deadband;
    logic [ClampW-1:0] r_turn_clamp;
    logic [LimitW-1:0] r_ramp_limit;

    logic              r_s1_valid;
    logic [KeyW-1:0]   r_s1_keys;
    logic signed [MouseW-1:0] r_s1_mouse;

    t_ramp             r_ramp [KeyW];
    t_ramp             n_ramp [KeyW];
    t_turn             r_turn_0, r_turn_1;
    t_turn             n_turn_0, n_turn_1;

    logic              r_out_valid;
    logic signed [WheelW-1:0] r_wheel [4];
    logic signed [WheelW-1:0] n_wheel [4];

    logic              out_free;
    logic              s1_adv;
    logic              in_acc;
    logic              cfg_wr;
    logic [2:0]        cfg_idx;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign s1_adv     = r_s1_valid && out_free;
    assign o_in_stall = r_s1_valid && !out_free;
    assign in_acc     = i_in_valid && !o_in_stall;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[4:2];
    assign cfg_wr  = psel && penable && pwrite;

    always_comb begin
        case (cfg_idx)
            RegRampStep:  prdata = {{(DataW-StepW){1'b0}}, r_ramp_step};
            RegDecayStep: prdata = {{(DataW-DecayW){1'b0}}, r_decay_step};
            RegDeadband:  prdata = {{(DataW-BandW){1'b0}}, r_deadband};
            RegTurnClamp: prdata = {{(DataW-ClampW){1'b0}}, r_turn_clamp};
            RegRampLimit: prdata = {{(DataW-LimitW){1'b0}}, r_ramp_limit};
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ramp_step  <= RstRampStep;
            r_decay_step <= RstDecayStep;
            r_deadband   <= RstDeadband;
            r_turn_clamp <= RstTurnClamp;
            r_ramp_limit <= RstRampLimit;
        end else if (cfg_wr) begin
            case (cfg_idx)
                RegRampStep:  r_ramp_step  <= pwdata[StepW-1:0];
                RegDecayStep: r_decay_step <= pwdata[DecayW-1:0];
                RegDeadband:  r_deadband   <= pwdata[BandW-1:0];
                RegTurnClamp: r_turn_clamp <= pwdata[ClampW-1:0];
                RegRampLimit: r_ramp_limit <= pwdata[LimitW-1:0];
                default: ;
            endcase
        end
    end

    // ramp update and wheel mix
    always_comb begin
        logic [RampW:0]          grow;
        logic [MouseW:0]         ax;
        logic [MouseW+16:0]      prod;
        logic [MouseW:0]         quot;
        logic [ClampW-1:0]       mag;
        logic signed [ClampW:0]  inc;
        logic                    turning;
        logic signed [TurnW:0]   lim_s;
        logic signed [TurnW:0]   dec_s;
        logic signed [TurnW:0]   t0_sum, t1_sum;
        logic signed [TurnW:0]   turn;
        logic signed [WheelW-1:0] fw, bk, lf, rt, tw;

        for (int k = 0; k < KeyW; k++) begin
            grow = {1'b0, r_ramp[k]} + {{(RampW+1-StepW){1'b0}}, r_ramp_step};
            if (r_s1_keys[k]) begin
                n_ramp[k] = (grow > {1'b0, r_ramp_limit}) ? r_ramp_limit : grow[RampW-1:0];
            end else if (r_ramp[k] > {{(RampW-DecayW){1'b0}}, r_decay_step}) begin
                n_ramp[k] = r_ramp[k] - {{(RampW-DecayW){1'b0}}, r_decay_step};
            end else begin
                n_ramp[k] = '0;
            end
        end

        ax = r_s1_mouse[MouseW-1] ? -{r_s1_mouse[MouseW-1], r_s1_mouse}
                                  : {1'b0, r_s1_mouse};
        prod = ax * RecipThree;
        quot = prod[RecipShift +: (MouseW+1)];
        mag  = (quot > {{(MouseW+1-ClampW){1'b0}}, r_turn_clamp})
             ? r_turn_clamp : quot[ClampW-1:0];
        inc  = r_s1_mouse[MouseW-1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
        turning = ax >= {{(MouseW+1-BandW){1'b0}}, r_deadband};

        lim_s  = $signed({2'b00, r_ramp_limit});
        dec_s  = $signed({{(TurnW+1-DecayW){1'b0}}, r_decay_step});
        t0_sum = $signed({r_turn_0[TurnW-1], r_turn_0})
               + {{(TurnW-ClampW){inc[ClampW]}}, inc};
        t1_sum = $signed({r_turn_1[TurnW-1], r_turn_1})
               - {{(TurnW-ClampW){inc[ClampW]}}, inc};

        if (turning) begin
            if (t0_sum > lim_s)       n_turn_0 = lim_s[TurnW-1:0];
            else if (t0_sum < -lim_s) n_turn_0 = t_turn'(-lim_s);
            else                      n_turn_0 = t0_sum[TurnW-1:0];
            if (t1_sum > lim_s)       n_turn_1 = lim_s[TurnW-1:0];
            else if (t1_sum < -lim_s) n_turn_1 = t_turn'(-lim_s);
            else                      n_turn_1 = t1_sum[TurnW-1:0];
        end else begin
            if ($signed({r_turn_0[TurnW-1], r_turn_0}) > dec_s)
                n_turn_0 = r_turn_0 - dec_s[TurnW-1:0];
            else if ($signed({r_turn_0[TurnW-1], r_turn_0}) < -dec_s)
                n_turn_0 = r_turn_0 + dec_s[TurnW-1:0];
            else
                n_turn_0 = '0;
            if ($signed({r_turn_1[TurnW-1], r_turn_1}) > dec_s)
                n_turn_1 = r_turn_1 - dec_s[TurnW-1:0];
            else if ($signed({r_turn_1[TurnW-1], r_turn_1}) < -dec_s)
                n_turn_1 = r_turn_1 + dec_s[TurnW-1:0];
            else
                n_turn_1 = '0;
        end

        turn = $signed({n_turn_0[TurnW-1], n_turn_0}) - $signed({n_turn_1[TurnW-1], n_turn_1});
        fw = $signed({{(WheelW-RampW){1'b0}}, n_ramp[KeyFwd]});
        bk = $signed({{(WheelW-RampW){1'b0}}, n_ramp[KeyBack]});
        lf = $signed({{(WheelW-RampW){1'b0}}, n_ramp[KeyLeft]});
        rt = $signed({{(WheelW-RampW){1'b0}}, n_ramp[KeyRight]});
        tw = {turn[TurnW], turn};

        n_wheel[0] = rt - lf + tw;
        n_wheel[1] = fw - bk + tw;
        n_wheel[2] = lf - rt + tw;
        n_wheel[3] = bk - fw + tw;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_turn_0    <= '0;
            r_turn_1    <= '0;
            for (int k = 0; k < KeyW; k++) begin
                r_ramp[k] <= '0;
            end
        end else begin
            if (in_acc) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
                r_turn_0    <= n_turn_0;
                r_turn_1    <= n_turn_1;
                for (int k = 0; k < KeyW; k++) begin
                    r_ramp[k] <= n_ramp[k];
                end
            end else if (out_free) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_keys  <= i_key_bits;
            r_s1_mouse <= i_mouse_x;
        end
        if (s1_adv) begin
            for (int w = 0; w < 4; w++) begin
                r_wheel[w] <= n_wheel[w];
            end
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_wheel_speed_0 = r_wheel[0];
    assign o_wheel_speed_1 = r_wheel[1];
    assign o_wheel_speed_2 = r_wheel[2];
    assign o_wheel_speed_3 = r_wheel[3];

    // turn ramps move in mirror image, so they always cancel
    a_turn_mirror: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_turn_0 + r_turn_1) == '0)
        else $error("turn ramps out of mirror");

    // opposite wheels share the same turn term
    a_mix_balance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |->
        ({o_wheel_speed_0[WheelW-1], o_wheel_speed_0}
            + {o_wheel_speed_2[WheelW-1], o_wheel_speed_2})
        == ({o_wheel_speed_1[WheelW-1], o_wheel_speed_1}
            + {o_wheel_speed_3[WheelW-1], o_wheel_speed_3}))
        else $error("wheel mix unbalanced");

    // a beat held in the input register is not dropped while the output stalls
    a_s1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !out_free) |=> r_s1_valid)
        else $error("input beat lost under stall");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> (!r_out_valid && !r_s1_valid))
        else $error("valid set after reset");

endmodule
